@@ hdl/pal_pkg.sv @@
// Package for the positional array list unit: field widths, command and status codes.
// No dependencies; used by the top level for operation and result codes.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    // Field widths of the item channels
    localparam int CMD_W = 2;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int IDX_W = 7;
    localparam int LEN_W = 8;
    localparam int STS_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

    // Status codes
    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef logic [VAL_W-1:0] t_word;

endpackage

`default_nettype wire

@@ hdl/pal_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/positional_array_list_unit.sv @@
// Positional array list unit: ordered list of signed words with insert, remove, read, find.
// Depends on pal_pkg (codes, widths) and pal_ram (entry store).
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  request  | in        | i_valid / o_stall  | i_command, i_position, i_value
//  result   | out       | o_valid / i_stall  | o_status, o_read_value, o_found_index,
//           |           |                    | o_list_length, o_is_empty
//
// Insert shifts the entries from the position up one place and then writes the new value;
// remove shifts the entries above the position down one place; read fetches one word;
// find scans from entry 0 to the first match. Refused requests go straight to the result.
// The single RAM port pair moves one entry per cycle. One request is in work at a time.
// Reset clears only the length and control; entries above the length are never read.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit #(
    parameter int CAPACITY = 128
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [pal_pkg::CMD_W-1:0]    i_command,
    input  wire logic [pal_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [pal_pkg::VAL_W-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [pal_pkg::STS_W-1:0]         o_status,
    output logic signed [pal_pkg::VAL_W-1:0]  o_read_value,
    output logic [pal_pkg::IDX_W-1:0]         o_found_index,
    output logic [pal_pkg::LEN_W-1:0]         o_list_length,
    output logic                              o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_DOWN = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]              r_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_left;
    logic                    r_rdv;
    logic [AW-1:0]           r_ptr;
    logic [AW-1:0]           r_wa;
    logic [AW-1:0]           r_pos;
    logic [AW-1:0]           r_fidx;
    pal_pkg::t_word          r_val;
    logic [pal_pkg::STS_W-1:0] r_res_status;
    pal_pkg::t_word          r_res_rd;
    logic [AW-1:0]           r_res_idx;

    logic                    w_issue;
    logic                    w_hit;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    pal_pkg::t_word          w_wdata;
    pal_pkg::t_word          w_rdata;
    logic [XW-1:0]           w_pos_x;
    logic [XW-1:0]           w_cnt_x;
    logic [XW-1:0]           w_cap_x;
    logic [XW-1:0]           w_len_x;
    logic [AW+7:0]           w_idx_x;
    logic                    w_out_free;

    assign w_pos_x    = XW'(i_position);
    assign w_cnt_x    = XW'(r_count);
    assign w_cap_x    = XW'(CAPACITY);
    assign w_len_x    = XW'(r_count);
    assign w_idx_x    = (AW + 8)'(r_res_idx);
    assign w_issue    = (r_left != '0);
    assign w_hit      = (r_state == S_FIND) && r_rdv && (w_rdata == r_val);
    assign w_out_free = !o_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);

    // Write port: shifted words, or the new value once an insert shift has drained
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wa;
        w_wdata = w_rdata;
        case (r_state)
            S_UP: begin
                if (r_rdv) begin
                    w_we = 1'b1;
                end else if (!w_issue) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_val;
                end
            end
            S_DOWN: begin
                w_we = r_rdv;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    pal_ram #(
        .WIDTH (pal_pkg::VAL_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // Sequencer: start a request, stream the entries, finish into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_rdv   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_rdv <= 1'b0;
                    if (i_valid) begin
                        r_val        <= pal_pkg::t_word'(i_value);
                        r_pos        <= AW'(w_pos_x);
                        r_res_rd     <= '0;
                        r_res_idx    <= '0;
                        case (i_command)
                            pal_pkg::CMD_INSERT: begin
                                if (w_pos_x > w_cnt_x) begin
                                    r_res_status <= pal_pkg::ST_BAD_POS;
                                    r_state      <= S_DONE;
                                end else if (w_cnt_x == w_cap_x) begin
                                    r_res_status <= pal_pkg::ST_FULL;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= pal_pkg::ST_OK;
                                    r_ptr   <= AW'(w_cnt_x - XW'(1));
                                    r_left  <= CW'(w_cnt_x - w_pos_x);
                                    r_state <= S_UP;
                                end
                            end
                            pal_pkg::CMD_REMOVE: begin
                                if (w_pos_x >= w_cnt_x) begin
                                    r_res_status <= pal_pkg::ST_BAD_POS;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= pal_pkg::ST_OK;
                                    r_ptr   <= AW'(w_pos_x + XW'(1));
                                    r_left  <= CW'(w_cnt_x - w_pos_x - XW'(1));
                                    r_state <= S_DOWN;
                                end
                            end
                            pal_pkg::CMD_READ: begin
                                if (w_pos_x >= w_cnt_x) begin
                                    r_res_status <= pal_pkg::ST_BAD_POS;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= pal_pkg::ST_OK;
                                    r_ptr   <= AW'(w_pos_x);
                                    r_left  <= CW'(1);
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_res_status <= pal_pkg::ST_OK;
                                r_ptr   <= '0;
                                r_left  <= r_count;
                                r_state <= S_FIND;
                            end
                        endcase
                    end
                end
                S_UP, S_DOWN, S_FIND, S_READ: begin
                    // Advance the read stream one entry per cycle; stop it on a match
                    r_rdv <= w_issue && !w_hit;
                    if (w_hit) begin
                        r_left <= '0;
                    end else if (w_issue) begin
                        r_left <= r_left - CW'(1);
                        r_fidx <= r_ptr;
                        if (r_state == S_UP) begin
                            r_ptr <= r_ptr - AW'(1);
                            r_wa  <= r_ptr + AW'(1);
                        end else begin
                            r_ptr <= r_ptr + AW'(1);
                            r_wa  <= r_ptr - AW'(1);
                        end
                    end
                    // Finish when the stream drains, or on the first match or read word
                    case (r_state)
                        S_UP: begin
                            if (!w_issue && !r_rdv) begin
                                r_count <= r_count + CW'(1);
                                r_state <= S_DONE;
                            end
                        end
                        S_DOWN: begin
                            if (!w_issue && !r_rdv) begin
                                r_count <= r_count - CW'(1);
                                r_state <= S_DONE;
                            end
                        end
                        S_READ: begin
                            if (r_rdv) begin
                                r_res_rd <= w_rdata;
                                r_state  <= S_DONE;
                            end
                        end
                        default: begin
                            if (w_hit) begin
                                r_res_idx <= r_fidx;
                                r_state   <= S_DONE;
                            end else if (!w_issue && !r_rdv) begin
                                r_res_status <= pal_pkg::ST_NOT_FOUND;
                                r_state      <= S_DONE;
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    r_rdv <= 1'b0;
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: load a finished result, drop the item once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            o_status      <= r_res_status;
            o_read_value  <= signed'(r_res_rd);
            o_found_index <= w_idx_x[pal_pkg::IDX_W-1:0];
            o_list_length <= w_len_x[pal_pkg::LEN_W-1:0];
            o_is_empty    <= (r_count == '0);
        end
    end

    // The length never passes the store size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (XW'(r_count) <= w_cap_x))
        else $error("list length above capacity");

    // The length changes only at the end of a shift
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_UP || r_state == S_DOWN) |=> $stable(r_count))
        else $error("list length changed outside a shift");

    // Lookups never write the store
    a_no_write_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND || r_state == S_READ || r_state == S_IDLE) |-> !w_we)
        else $error("store written during a lookup");

    // No read word is pending once the sequencer is idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rdv && !w_issue))
        else $error("read stream active while idle");

endmodule

`default_nettype wire
